// ===== hdl/pgdd_pkg.sv =====
// Shared constants, types and register indexes of the packed grid difference decoder.
`timescale 1ns / 1ps

package pgdd_pkg;

   localparam int MAX_COLUMNS   = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int FRACTION_BITS = 24;

   localparam int VALUE_WIDTH = 48;
   localparam int BYTE_WIDTH  = 8;
   localparam int EXP_WIDTH   = 6;
   localparam int COL_WIDTH   = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_WIDTH   = $clog2(MAX_ROWS + 1);
   localparam int CIDX_WIDTH  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RIDX_WIDTH  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CSR_DATA_WIDTH = VALUE_WIDTH;

   // Byte value that encodes a zero difference, and the exponent of an unscaled byte.
   localparam int BYTE_BIAS   = 127;
   localparam int EXP_BIAS    = 7;
   localparam int SHIFT_BIAS  = FRACTION_BITS - EXP_BIAS;

   // Difference magnitude before the sign: wide enough for the largest left shift.
   localparam int SHIFT_WIDTH     = 8;
   localparam int MAG_WIDTH       = VALUE_WIDTH + 9;
   localparam int OVERSIZE_SHIFT  = VALUE_WIDTH + 2;
   localparam int SUM_WIDTH       = MAG_WIDTH + 2;

   typedef enum logic [1:0] {
      CSR_GRID_COLUMNS   = 2'd0,
      CSR_GRID_ROWS      = 2'd1,
      CSR_SCALE_EXPONENT = 2'd2,
      CSR_FIRST_VALUE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COL_WIDTH-1:0]          columns;
      logic [ROW_WIDTH-1:0]          rows;
      logic signed [EXP_WIDTH-1:0]   scale_exponent;
      logic signed [VALUE_WIDTH-1:0] first_value;
   } cfg_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          saturated;
   } sum_type;

endpackage

// ===== hdl/packed_grid_difference_decoder_top.sv =====
// Top level of the packed grid difference decoder: input register, position and result register.
//
// Usage: packed bytes arrive on the req_ channel, one grid point per item, scanned row by row.
// Each accepted item yields exactly one rsp_ item: the decoded 48-bit value (24 fraction bits),
// end_of_row, end_of_grid and a saturated flag. Both channels move an item on a clock edge with
// valid high and stall low.
// An accepted item waits in the input register, and the scale and saturating add then load
// the result register, where rsp_valid rises; the result is taken from there. Throughput is
// one item per cycle while the receiver does not stall, set by the single add between the
// input and result registers; the running value feeds back in the same cycle.
// When the receiver stalls, the result register holds and the input register still takes one
// more item; req_stall rises only when both are full.
// Reset clears both registers, the grid position and the running values, and loads the
// defaults: one column, one row, exponent 7, first value 0. Write the csr_ registers only while
// no item is in flight. After the last point of a grid the next grid starts from first_value.
`timescale 1ns / 1ps

module packed_grid_difference_decoder_top (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_enable,
   input  pgdd_pkg::csr_index_type                    csr_index,
   input  logic [pgdd_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [pgdd_pkg::BYTE_WIDTH-1:0]            req_packed_byte,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [pgdd_pkg::VALUE_WIDTH-1:0]    rsp_value,
   output logic                                       rsp_end_of_row,
   output logic                                       rsp_end_of_grid,
   output logic                                       rsp_saturated
);
   import pgdd_pkg::*;

   cfg_type cfg;
   sum_type sum;

   logic                          in_valid_ff;
   logic [BYTE_WIDTH-1:0]         in_byte_ff;
   logic                          out_valid_ff;
   logic signed [VALUE_WIDTH-1:0] out_value_ff;
   logic                          out_eor_ff;
   logic                          out_eog_ff;
   logic                          out_sat_ff;
   logic signed [VALUE_WIDTH-1:0] running_ff;
   logic signed [VALUE_WIDTH-1:0] row_start_ff;
   logic [CIDX_WIDTH-1:0]         column_ff;
   logic [RIDX_WIDTH-1:0]         row_ff;
   logic [CIDX_WIDTH-1:0]         column_in;
   logic [RIDX_WIDTH-1:0]         row_in;

   logic                          out_ready;
   logic                          advance;
   logic                          req_accept;
   logic signed [VALUE_WIDTH-1:0] base;
   logic                          eor;
   logic                          eog;

   pgdd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pgdd_datapath u_datapath (
      .packed_byte    (in_byte_ff),
      .scale_exponent (cfg.scale_exponent),
      .base           (base),
      .result         (sum)
   );

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (column_ff != '0) begin
         base = running_ff;
      end else if (row_ff == '0) begin
         base = cfg.first_value;
      end else begin
         base = row_start_ff;
      end

      // The position may sit past a shrunken size, so the ends compare with >=.
      eor = ({1'b0, column_ff} + (CIDX_WIDTH + 1)'(1)) >= (CIDX_WIDTH + 1)'(cfg.columns);
      eog = eor && (({1'b0, row_ff} + (RIDX_WIDTH + 1)'(1)) >= (RIDX_WIDTH + 1)'(cfg.rows));

      if (eor) begin
         column_in = '0;
         row_in    = eog ? '0 : row_ff + RIDX_WIDTH'(1);
      end else begin
         column_in = column_ff + CIDX_WIDTH'(1);
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         running_ff   <= '0;
         row_start_ff <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            running_ff <= sum.value;
            if (column_ff == '0) begin
               row_start_ff <= sum.value;
            end
            column_ff <= column_in;
            row_ff    <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_packed_byte;
      end
      if (advance) begin
         out_value_ff <= sum.value;
         out_eor_ff   <= eor;
         out_eog_ff   <= eog;
         out_sat_ff   <= sum.saturated;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_end_of_row  = out_eor_ff;
   assign rsp_end_of_grid = out_eog_ff;
   assign rsp_saturated   = out_sat_ff;

   a_eog_has_eor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_eog_ff |-> out_eor_ff)
      else $error("end of grid reported without end of row");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled while a register was free");

   a_row_end_resets_column: assert property (@(posedge clock) disable iff (reset)
      advance && eor |=> column_ff == '0)
      else $error("column position not cleared after end of row");

   a_saturated_at_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_sat_ff |->
         out_value_ff == {1'b1, {(VALUE_WIDTH - 1){1'b0}}} ||
         out_value_ff == {1'b0, {(VALUE_WIDTH - 1){1'b1}}})
      else $error("saturated result not at a range limit");

   a_grid_end_resets_row: assert property (@(posedge clock) disable iff (reset)
      advance && eog |=> row_ff == '0 && column_ff == '0)
      else $error("grid position not cleared after end of grid");

endmodule

// ===== hdl/pgdd_csr.sv =====
// Configuration registers of the decoder, with the grid sizes clamped to their legal range.
`timescale 1ns / 1ps

module pgdd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  pgdd_pkg::csr_index_type             csr_index,
   input  logic [pgdd_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output pgdd_pkg::cfg_type                   cfg
);
   import pgdd_pkg::*;

   logic [COL_WIDTH-1:0]          columns_ff;
   logic [ROW_WIDTH-1:0]          rows_ff;
   logic signed [EXP_WIDTH-1:0]   exponent_ff;
   logic signed [VALUE_WIDTH-1:0] first_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff     <= COL_WIDTH'(1);
         rows_ff        <= ROW_WIDTH'(1);
         exponent_ff    <= EXP_WIDTH'(EXP_BIAS);
         first_value_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS:   columns_ff     <= csr_write_data[COL_WIDTH-1:0];
            CSR_GRID_ROWS:      rows_ff        <= csr_write_data[ROW_WIDTH-1:0];
            CSR_SCALE_EXPONENT: exponent_ff    <= csr_write_data[EXP_WIDTH-1:0];
            CSR_FIRST_VALUE:    first_value_ff <= csr_write_data[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero acts as one, and sizes past the maximum act as the maximum.
   always_comb begin
      if (columns_ff == '0) begin
         cfg.columns = COL_WIDTH'(1);
      end else if (columns_ff > COL_WIDTH'(MAX_COLUMNS)) begin
         cfg.columns = COL_WIDTH'(MAX_COLUMNS);
      end else begin
         cfg.columns = columns_ff;
      end
      if (rows_ff == '0) begin
         cfg.rows = ROW_WIDTH'(1);
      end else if (rows_ff > ROW_WIDTH'(MAX_ROWS)) begin
         cfg.rows = ROW_WIDTH'(MAX_ROWS);
      end else begin
         cfg.rows = rows_ff;
      end
      cfg.scale_exponent = exponent_ff;
      cfg.first_value    = first_value_ff;
   end

endmodule

// ===== hdl/pgdd_datapath.sv =====
// Scales one packed byte into a fixed point difference and adds it to the base with saturation.
`timescale 1ns / 1ps

module pgdd_datapath (
   input  logic [pgdd_pkg::BYTE_WIDTH-1:0]         packed_byte,
   input  logic signed [pgdd_pkg::EXP_WIDTH-1:0]   scale_exponent,
   input  logic signed [pgdd_pkg::VALUE_WIDTH-1:0] base,
   output pgdd_pkg::sum_type                       result
);
   import pgdd_pkg::*;

   logic signed [BYTE_WIDTH:0]    diff_raw;
   logic [BYTE_WIDTH-1:0]         mag;
   logic [MAG_WIDTH-1:0]          mag_ext;
   logic signed [SHIFT_WIDTH-1:0] shift;
   logic [SHIFT_WIDTH-1:0]        right_shift;
   logic [MAG_WIDTH-1:0]          scaled;
   logic signed [SUM_WIDTH-1:0]   diff;
   logic signed [SUM_WIDTH-1:0]   sum;
   logic                          overflow;

   always_comb begin
      diff_raw = $signed({1'b0, packed_byte}) - (BYTE_WIDTH + 1)'(BYTE_BIAS);
      mag      = diff_raw[BYTE_WIDTH] ? BYTE_WIDTH'(-diff_raw) : diff_raw[BYTE_WIDTH-1:0];
      mag_ext  = MAG_WIDTH'(mag);

      shift = $signed({{(SHIFT_WIDTH - EXP_WIDTH){scale_exponent[EXP_WIDTH-1]}},
                       scale_exponent}) + SHIFT_WIDTH'(SHIFT_BIAS);
      right_shift = SHIFT_WIDTH'(-shift);

      // A nonzero difference shifted past the value width counts as far out of range, so the sum saturates.
      if (mag == '0) begin
         scaled = '0;
      end else if (shift > SHIFT_WIDTH'(VALUE_WIDTH)) begin
         scaled = MAG_WIDTH'(1) << OVERSIZE_SHIFT;
      end else if (!shift[SHIFT_WIDTH-1]) begin
         scaled = mag_ext << shift[SHIFT_WIDTH-2:0];
      end else begin
         scaled = mag_ext >> right_shift;
      end

      diff = diff_raw[BYTE_WIDTH] ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
      sum  = $signed({{(SUM_WIDTH - VALUE_WIDTH){base[VALUE_WIDTH-1]}}, base}) + diff;

      // Out of range when the bits above the value's sign do not all match it.
      overflow = (sum[SUM_WIDTH-1:VALUE_WIDTH-1] != '0) &&
                 (sum[SUM_WIDTH-1:VALUE_WIDTH-1] != '1);
      result.saturated = overflow;
      if (!overflow) begin
         result.value = sum[VALUE_WIDTH-1:0];
      end else if (sum[SUM_WIDTH-1]) begin
         result.value = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
      end else begin
         result.value = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
      end
   end

endmodule

// ===== test/tb_packed_grid_difference_decoder_top.sv =====
// Self-checking testbench for the packed grid difference decoder: directed and random grids.
`timescale 1ns / 1ps

module tb_packed_grid_difference_decoder_top;
   import pgdd_pkg::*;

   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          end_of_row;
      logic                          end_of_grid;
      logic                          saturated;
   } grid_point_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   csr_index_type                     csr_index;
   logic [CSR_DATA_WIDTH-1:0]         csr_write_data;
   logic                              req_valid;
   logic                              req_stall;
   logic [BYTE_WIDTH-1:0]             req_packed_byte;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0]     rsp_value;
   logic                              rsp_end_of_row;
   logic                              rsp_end_of_grid;
   logic                              rsp_saturated;

   // Decoder copy: configuration and grid position as the block should hold them.
   logic [COL_WIDTH-1:0]              cfg_columns = 1;
   logic [ROW_WIDTH-1:0]              cfg_rows = 1;
   logic signed [EXP_WIDTH-1:0]       cfg_exponent = 7;
   logic signed [VALUE_WIDTH-1:0]     cfg_first = 0;
   longint                            running_value = 0;
   longint                            row_start_value = 0;
   int                                column_pos = 0;
   int                                row_pos = 0;

   grid_point_type                    expected_points[$];
   int                                failures = 0;
   int                                quiet_cycles = 0;
   bit                                idling_on = 1;
   int                                rsp_hold_request = 0;
   bit                                rsp_hold_taken = 0;
   int                                rsp_hold_left = 0;
   int                                rsp_burst_left = 0;
   int                                rsp_calm_left = 0;
   int                                req_calm_left = 0;

   packed_grid_difference_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_packed_byte  (req_packed_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_grid  (rsp_end_of_grid),
      .rsp_saturated    (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Computes the decoded point for one accepted byte and advances the grid position.
   function automatic void decode_point(input logic [BYTE_WIDTH-1:0] packed_byte);
      longint diff, mag, base, sum;
      int shift, cols, rows;
      grid_point_type want;
      cols = (cfg_columns == 0) ? 1 : (cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS
                                                                 : int'(cfg_columns);
      rows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      diff = longint'(packed_byte) - BYTE_BIAS;
      mag = (diff < 0) ? -diff : diff;
      shift = FRACTION_BITS + int'(cfg_exponent) - EXP_BIAS;
      // A nonzero difference past the value width is pushed far out of range.
      if (mag == 0) begin
         mag = 0;
      end else if (shift > VALUE_WIDTH) begin
         mag = longint'(1) <<< OVERSIZE_SHIFT;
      end else if (shift >= 0) begin
         mag = mag << shift;
      end else if (-shift >= 63) begin
         mag = 0;
      end else begin
         mag = mag >> (-shift);
      end
      diff = (diff < 0) ? -mag : mag;

      if (column_pos == 0) begin
         base = (row_pos == 0) ? longint'(cfg_first) : row_start_value;
      end else begin
         base = running_value;
      end
      sum = base + diff;
      want.saturated = 1'b0;
      if (sum > VALUE_MAX) begin
         sum = VALUE_MAX;
         want.saturated = 1'b1;
      end
      if (sum < VALUE_MIN) begin
         sum = VALUE_MIN;
         want.saturated = 1'b1;
      end
      if (column_pos == 0) begin
         row_start_value = sum;
      end
      running_value = sum;

      want.value = sum[VALUE_WIDTH-1:0];
      want.end_of_row = (column_pos + 1 >= cols);
      want.end_of_grid = want.end_of_row && (row_pos + 1 >= rows);
      if (want.end_of_row) begin
         column_pos = 0;
         row_pos = want.end_of_grid ? 0 : row_pos + 1;
      end else begin
         column_pos++;
      end
      expected_points.push_back(want);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_byte();
      if ($urandom_range(0, 3) == 0) begin
         return BYTE_WIDTH'($urandom_range(BYTE_BIAS - 7, BYTE_BIAS + 7));
      end
      return BYTE_WIDTH'($urandom_range(0, 255));
   endfunction

   function automatic longint random_first_value();
      logic [63:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return VALUE_MAX - longint'($urandom_range(0, 1 << 30));
         1: return VALUE_MIN + longint'($urandom_range(0, 1 << 30));
         2: return longint'($signed(word[VALUE_WIDTH-1:0]));
         default: return longint'(int'(word[31:0]));
      endcase
   endfunction

   // Fills the unused upper bits of a narrow register write with random data.
   function automatic logic [CSR_DATA_WIDTH-1:0] with_noise(input int field, input int width);
      logic [63:0] word;
      word = {$urandom, $urandom};
      for (int b = 0; b < width; b++) begin
         word[b] = field[b];
      end
      return word[CSR_DATA_WIDTH-1:0];
   endfunction

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_GRID_COLUMNS:   cfg_columns = data[COL_WIDTH-1:0];
         CSR_GRID_ROWS:      cfg_rows = data[ROW_WIDTH-1:0];
         CSR_SCALE_EXPONENT: cfg_exponent = data[EXP_WIDTH-1:0];
         CSR_FIRST_VALUE:    cfg_first = data[VALUE_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_grid(input int cols, input int rows, input int exponent,
                                 input longint first);
      write_register(CSR_GRID_COLUMNS, with_noise(cols, COL_WIDTH));
      write_register(CSR_GRID_ROWS, with_noise(rows, ROW_WIDTH));
      write_register(CSR_SCALE_EXPONENT, with_noise(exponent, EXP_WIDTH));
      write_register(CSR_FIRST_VALUE, first[VALUE_WIDTH-1:0]);
   endtask

   // Offers one item and returns at the edge that accepts it, with valid still high.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] packed_byte);
      int gap;
      gap = 0;
      if (idling_on) begin
         if (req_calm_left > 0) begin
            req_calm_left--;
         end else if ($urandom_range(0, 49) == 0) begin
            req_calm_left = $urandom_range(20, 80);
         end else if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_packed_byte <= packed_byte;
      do @(posedge clock); while (req_stall);
      decode_point(packed_byte);
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_byte(8'd127);
      send_byte(8'd255);
      send_byte(8'd0);
   endtask

   // Largest exponent: every nonzero difference saturates against an extreme first value.
   task automatic test_extremes();
      settle_block();
      configure_grid(3, 2, 31, VALUE_MAX);
      send_byte(8'd128);
      send_byte(8'd127);
      send_byte(8'd126);
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(8'd127);
   endtask

   // Right shifts truncate toward zero; zero sizes act as one.
   task automatic test_truncation();
      settle_block();
      configure_grid(0, 0, -32, VALUE_MIN);
      send_byte(8'd0);
      send_byte(8'd255);
      settle_block();
      configure_grid(2, 1, -24, 0);
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(8'd128);
      send_byte(8'd126);
   endtask

   // Shrinking the grid mid-way keeps the position; a row ends once it is passed.
   task automatic test_mid_grid_change();
      settle_block();
      configure_grid(4, 3, 7, random_first_value());
      repeat (3) send_byte(random_byte());
      settle_block();
      write_register(CSR_GRID_COLUMNS, with_noise(2, COL_WIDTH));
      send_byte(random_byte());
      send_byte(random_byte());
      settle_block();
      write_register(CSR_GRID_ROWS, with_noise(1, ROW_WIDTH));
      send_byte(random_byte());
   endtask

   task automatic test_back_pressure();
      settle_block();
      configure_grid(5, 4, 3, random_first_value());
      idling_on = 0;
      rsp_hold_request = 80;
      repeat (30) send_byte(random_byte());
      idling_on = 1;
   endtask

   task automatic test_random_grids(input int count);
      int sent, cols, rows, points;
      sent = 0;
      while (sent < count) begin
         settle_block();
         cols = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
         rows = $urandom_range(0, 6);
         if ($urandom_range(0, 3) != 0) begin
            write_register(CSR_GRID_COLUMNS, with_noise(cols, COL_WIDTH));
            write_register(CSR_GRID_ROWS, with_noise(rows, ROW_WIDTH));
         end
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_SCALE_EXPONENT,
                           with_noise(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                      : $urandom_range(0, 16) - 10, EXP_WIDTH));
         end
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_FIRST_VALUE, CSR_DATA_WIDTH'(random_first_value()));
         end
         points = ((cfg_columns == 0) ? 1 : int'(cfg_columns))
                  * ((cfg_rows == 0) ? 1 : int'(cfg_rows));
         // Now and then a grid is cut short, so the next one starts mid-way.
         if ($urandom_range(0, 5) == 0) begin
            points = $urandom_range(1, points);
         end
         repeat (points) send_byte(random_byte());
         sent += points;
      end
   endtask

   // Sizes beyond the limit clamp: one full-length row, then a column that does not end early.
   task automatic test_size_clamp();
      settle_block();
      configure_grid(2047, 1, $urandom_range(0, 10) - 5, random_first_value());
      repeat (MAX_COLUMNS) send_byte(random_byte());
      settle_block();
      configure_grid(1, 2047, $urandom_range(0, 10) - 5, random_first_value());
      repeat (24) send_byte(random_byte());
      settle_block();
      write_register(CSR_GRID_ROWS, with_noise(1, ROW_WIDTH));
   endtask

   // Receiver: random stall bursts, calm stretches, and one long hold on request.
   always @(negedge clock) begin
      if (rsp_hold_request > 0 && !rsp_hold_taken) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_taken = 1'b1;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_burst_left > 0) begin
         rsp_burst_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && rsp_calm_left == 0 && $urandom_range(0, 9) == 0) begin
         rsp_burst_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_calm_left > 0) begin
            rsp_calm_left--;
         end else if ($urandom_range(0, 59) == 0) begin
            rsp_calm_left = $urandom_range(20, 80);
         end
      end
   end

   always @(posedge clock) begin : check_points
      grid_point_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_value, rsp_end_of_row, rsp_end_of_grid, rsp_saturated};
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected item value=%0d eor=%0b eog=%0b sat=%0b", $time,
                     got.value, got.end_of_row, got.end_of_grid, got.saturated);
            failures++;
         end else begin
            want = expected_points.pop_front();
            if (got !== want) begin
               $display("%0t: expected value=%0d eor=%0b eog=%0b sat=%0b, got %0d %0b %0b %0b",
                        $time, want.value, want.end_of_row, want.end_of_grid, want.saturated,
                        got.value, got.end_of_row, got.end_of_grid, got.saturated);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
      begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** packed_grid_difference_decoder_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_packed_byte = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_GRID_COLUMNS;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extremes();
      test_truncation();
      test_mid_grid_change();
      test_back_pressure();
      test_random_grids(200);
      test_size_clamp();
      idling_on = 0;
      test_random_grids(60);
      settle_block();

      if (failures == 0) begin
         $display("** packed_grid_difference_decoder_top: PASSED **");
      end else begin
         $display("** packed_grid_difference_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
